@@ design/kwm_pkg.sv @@
// Shared types, constants and helper functions for the k-way merge heap.
// Used by kwm_cmp, the heap unit and the bench; has no dependencies of its own.
package kwm_pkg;

   localparam int NUM_LISTS  = 16;
   localparam int VALUE_BITS = 32;
   localparam int TAG_BITS   = 4;
   localparam int IDX_BITS   = $clog2(NUM_LISTS);
   localparam int CNT_BITS   = $clog2(NUM_LISTS + 1);
   localparam int ELEM_BITS  = 32;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] value;
      logic [TAG_BITS-1:0]          tag;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   typedef enum logic [1:0] {
      OP_INSERT  = 2'd0,
      OP_REPLACE = 2'd1,
      OP_POP     = 2'd2,
      OP_CLEAR   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SIFT_UP,
      S_POP_LOAD,
      S_SD_CHILD,
      S_SD_MOVE,
      S_PLACE,
      S_FINISH
   } state_type;

   // Sign-extends or truncates an input element to the stored value width.
   function automatic logic signed [VALUE_BITS-1:0] load_value(input logic [ELEM_BITS-1:0] e);
      logic signed [VALUE_BITS-1:0] r;
      for (int b = 0; b < VALUE_BITS; b++) begin
         r[b] = e[(b < ELEM_BITS) ? b : ELEM_BITS - 1];
      end
      return r;
   endfunction

   // Sign-extends or truncates a stored value back to the output width.
   function automatic logic [ELEM_BITS-1:0] emit_value(input logic signed [VALUE_BITS-1:0] v);
      logic [ELEM_BITS-1:0] r;
      for (int b = 0; b < ELEM_BITS; b++) begin
         r[b] = v[(b < VALUE_BITS) ? b : VALUE_BITS - 1];
      end
      return r;
   endfunction

endpackage

@@ design/kwm_ram.sv @@
// Generic RAM with one write port and two registered read ports.
// No package dependencies.
module kwm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

@@ design/kwm_cmp.sv @@
// Heap order comparator: signed value first, lower tag wins a tie.
// Depends on kwm_pkg for the entry type.
module kwm_cmp (
   input  kwm_pkg::entry_type a,
   input  kwm_pkg::entry_type b,
   output logic               a_before_b
);

   always_comb begin
      if (a.value != b.value) begin
         a_before_b = (a.value < b.value);
      end else begin
         a_before_b = (a.tag < b.tag);
      end
   end

endmodule

@@ design/k_way_merge_min_heap_unit.sv @@
// K-way merge min-heap: sift sequencer, entry RAM and comparator. Needs kwm_pkg, kwm_ram, kwm_cmp.
// Clear, errors, insert into an empty heap and pop of the last entry go straight to the finish
// step; insert sifts up level by level; replace, and pop after loading the last entry, sift
// down with a child-compare and a move step per level. req_tready stays low meanwhile, and
// the finish step repeats while the previous response still waits. Synchronous reset empties it.
module k_way_merge_min_heap_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // elem_value[31:0], list_tag[35:32], zero pad
   input  logic [1:0]  req_tuser,  // opcode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata   // out_value[31:0], out_valid[32], out_tag[36:33],
                                   // top_tag[40:37], heap_empty[41], status[43:42], pad
);

   localparam int IW = kwm_pkg::IDX_BITS;
   localparam int CW = kwm_pkg::CNT_BITS;
   localparam int XW = kwm_pkg::IDX_BITS + 2;

   kwm_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic [IW-1:0]      win_idx_ff, win_idx_in;
   kwm_pkg::entry_type x_ff, x_in;
   kwm_pkg::entry_type win_ff, win_in;
   kwm_pkg::entry_type top_ff;
   logic [31:0]        res_val_ff, res_val_in;
   logic               res_valid_ff, res_valid_in;
   logic [3:0]         res_tag_ff, res_tag_in;
   kwm_pkg::status_type res_status_ff, res_status_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [47:0]        rsp_tdata_ff, rsp_tdata_in;

   logic               wr_en;
   logic [IW-1:0]      wr_addr, rd_addr_a, rd_addr_b;
   kwm_pkg::entry_type wr_data, rd_data_a, rd_data_b;
   kwm_pkg::entry_type cmp_a, cmp_b;
   logic               cmp_lt;

   kwm_pkg::op_type    op;
   kwm_pkg::entry_type req_entry;
   logic [IW-1:0]      parent;
   logic [XW-1:0]      left_x, right_x, count_x;
   logic               req_fire;

   kwm_ram #(
      .WIDTH (kwm_pkg::ENTRY_BITS),
      .DEPTH (kwm_pkg::NUM_LISTS)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   kwm_cmp u_cmp (
      .a          (cmp_a),
      .b          (cmp_b),
      .a_before_b (cmp_lt)
   );

   assign req_tready = (state_ff == kwm_pkg::S_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   assign op              = kwm_pkg::op_type'(req_tuser);
   assign req_entry.value = kwm_pkg::load_value(req_tdata[31:0]);
   assign req_entry.tag   = req_tdata[35:32];

   assign parent  = IW'((idx_ff - IW'(1)) >> 1);
   assign left_x  = {1'b0, idx_ff, 1'b1};
   assign right_x = left_x + XW'(1);
   assign count_x = XW'(count_ff);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      win_idx_in    = win_idx_ff;
      x_in          = x_ff;
      win_in        = win_ff;
      res_val_in    = res_val_ff;
      res_valid_in  = res_valid_ff;
      res_tag_in    = res_tag_ff;
      res_status_in = res_status_ff;
      rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = x_ff;
      rd_addr_a     = IW'(1);
      rd_addr_b     = IW'(2);
      cmp_a         = x_ff;
      cmp_b         = rd_data_a;

      unique case (state_ff)
         kwm_pkg::S_IDLE: begin
            if (req_fire) begin
               res_val_in    = '0;
               res_valid_in  = 1'b0;
               res_tag_in    = '0;
               res_status_in = kwm_pkg::ST_OK;
               state_in      = kwm_pkg::S_FINISH;
               unique case (op)
                  kwm_pkg::OP_INSERT: begin
                     if (count_ff == CW'(kwm_pkg::NUM_LISTS)) begin
                        res_status_in = kwm_pkg::ST_FULL;
                     end else begin
                        count_in = count_ff + CW'(1);
                        x_in     = req_entry;
                        idx_in   = IW'(count_ff);
                        if (count_ff == '0) begin
                           wr_en   = 1'b1;
                           wr_addr = '0;
                           wr_data = req_entry;
                        end else begin
                           rd_addr_a = IW'((count_ff - CW'(1)) >> 1);
                           state_in  = kwm_pkg::S_SIFT_UP;
                        end
                     end
                  end
                  kwm_pkg::OP_REPLACE, kwm_pkg::OP_POP: begin
                     if (count_ff == '0) begin
                        res_status_in = kwm_pkg::ST_EMPTY;
                     end else begin
                        res_val_in   = kwm_pkg::emit_value(top_ff.value);
                        res_valid_in = 1'b1;
                        res_tag_in   = top_ff.tag;
                        idx_in       = '0;
                        if (op == kwm_pkg::OP_REPLACE) begin
                           x_in.value = req_entry.value;
                           x_in.tag   = top_ff.tag;
                           state_in   = kwm_pkg::S_SD_CHILD;
                        end else begin
                           count_in  = count_ff - CW'(1);
                           rd_addr_a = IW'(count_ff - CW'(1));
                           // Popping the only entry leaves nothing to rebuild.
                           if (count_ff != CW'(1)) begin
                              state_in = kwm_pkg::S_POP_LOAD;
                           end
                        end
                     end
                  end
                  kwm_pkg::OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     count_in = count_ff;
                  end
               endcase
            end
         end

         kwm_pkg::S_SIFT_UP: begin
            // The moving entry is kept in x_ff; parents shift down into the hole.
            cmp_a = x_ff;
            cmp_b = rd_data_a;
            if (cmp_lt) begin
               wr_en   = 1'b1;
               wr_addr = idx_ff;
               wr_data = rd_data_a;
               idx_in  = parent;
               if (parent == '0) begin
                  state_in = kwm_pkg::S_PLACE;
               end else begin
                  rd_addr_a = IW'((parent - IW'(1)) >> 1);
               end
            end else begin
               wr_en    = 1'b1;
               state_in = kwm_pkg::S_FINISH;
            end
         end

         kwm_pkg::S_POP_LOAD: begin
            x_in     = rd_data_a;
            state_in = kwm_pkg::S_SD_CHILD;
         end

         kwm_pkg::S_SD_CHILD: begin
            cmp_a = rd_data_b;
            cmp_b = rd_data_a;
            if (left_x >= count_x) begin
               wr_en    = 1'b1;
               state_in = kwm_pkg::S_FINISH;
            end else begin
               state_in = kwm_pkg::S_SD_MOVE;
               if (right_x < count_x && cmp_lt) begin
                  win_in     = rd_data_b;
                  win_idx_in = IW'(right_x);
               end else begin
                  win_in     = rd_data_a;
                  win_idx_in = IW'(left_x);
               end
            end
         end

         kwm_pkg::S_SD_MOVE: begin
            cmp_a = win_ff;
            cmp_b = x_ff;
            if (cmp_lt) begin
               wr_en     = 1'b1;
               wr_data   = win_ff;
               idx_in    = win_idx_ff;
               rd_addr_a = IW'({win_idx_ff, 1'b1});
               rd_addr_b = IW'({win_idx_ff, 1'b1} + (IW + 1)'(1));
               state_in  = kwm_pkg::S_SD_CHILD;
            end else begin
               wr_en    = 1'b1;
               state_in = kwm_pkg::S_FINISH;
            end
         end

         kwm_pkg::S_PLACE: begin
            wr_en    = 1'b1;
            state_in = kwm_pkg::S_FINISH;
         end

         kwm_pkg::S_FINISH: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {4'b0, res_status_ff, (count_ff == '0),
                                (count_ff == '0) ? 4'b0 : top_ff.tag,
                                res_tag_ff, res_valid_ff, res_val_ff};
               state_in      = kwm_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = kwm_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= kwm_pkg::S_IDLE;
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // The root is mirrored here so that emission and the top tag need no RAM read.
   always_ff @(posedge clock) begin
      if (wr_en && wr_addr == '0) begin
         top_ff <= wr_data;
      end
      idx_ff        <= idx_in;
      win_idx_ff    <= win_idx_in;
      x_ff          <= x_in;
      win_ff        <= win_in;
      res_val_ff    <= res_val_in;
      res_valid_ff  <= res_valid_in;
      res_tag_ff    <= res_tag_in;
      res_status_ff <= res_status_in;
      rsp_tdata_ff  <= rsp_tdata_in;
   end

endmodule

@@ tb/kwm_tb_pkg.sv @@
// Mirror of the k-way merge heap: predicts each response and checks the ones that arrive.
// Depends on kwm_pkg for the entry, opcode and status types.
package kwm_tb_pkg;

   timeunit 1ns;
   timeprecision 1ps;

   import kwm_pkg::*;

   typedef struct {
      logic [ELEM_BITS-1:0] value;
      logic                 valid;
      logic [TAG_BITS-1:0]  tag;
      logic [TAG_BITS-1:0]  top;
      logic                 empty;
      status_type           status;
   } merge_result_type;

   class merge_heap_mirror;
      entry_type        heap [NUM_LISTS];
      int unsigned      fill;
      merge_result_type pending_results [$];
      int unsigned      errors;

      function new();
         fill   = 0;
         errors = 0;
      endfunction

      // Smaller value first; equal values go to the lower tag.
      function bit precedes(entry_type a, entry_type b);
         if (a.value != b.value) begin
            return $signed(a.value) < $signed(b.value);
         end
         return a.tag < b.tag;
      endfunction

      function void swap_slots(int i, int j);
         entry_type t;
         t       = heap[i];
         heap[i] = heap[j];
         heap[j] = t;
      endfunction

      function void sift_down();
         int i;
         int l;
         int m;
         i = 0;
         forever begin
            l = 2 * i + 1;
            m = i;
            if (l < fill && precedes(heap[l], heap[m])) m = l;
            if (l + 1 < fill && precedes(heap[l + 1], heap[m])) m = l + 1;
            if (m == i) break;
            swap_slots(i, m);
            i = m;
         end
      endfunction

      function int unsigned size();
         return fill;
      endfunction

      function logic [TAG_BITS-1:0] top_tag();
         return (fill > 0) ? heap[0].tag : '0;
      endfunction

      function int unsigned pending();
         return pending_results.size();
      endfunction

      // Applies one accepted item to the mirror and queues the response it must produce.
      function void note_request(op_type op, logic [ELEM_BITS-1:0] elem,
                                 logic [TAG_BITS-1:0] tag);
         merge_result_type r;
         int i;
         r.value  = '0;
         r.valid  = 1'b0;
         r.tag    = '0;
         r.status = ST_OK;
         case (op)
            OP_INSERT: begin
               if (fill >= NUM_LISTS) begin
                  r.status = ST_FULL;
               end else begin
                  heap[fill].value = elem;
                  heap[fill].tag   = tag;
                  i = fill;
                  fill++;
                  while (i > 0 && precedes(heap[i], heap[(i - 1) / 2])) begin
                     swap_slots(i, (i - 1) / 2);
                     i = (i - 1) / 2;
                  end
               end
            end
            OP_REPLACE, OP_POP: begin
               if (fill == 0) begin
                  r.status = ST_EMPTY;
               end else begin
                  r.value = heap[0].value;
                  r.valid = 1'b1;
                  r.tag   = heap[0].tag;
                  if (op == OP_REPLACE) begin
                     heap[0].value = elem;
                  end else begin
                     fill--;
                     heap[0] = heap[fill];
                  end
                  sift_down();
               end
            end
            default: begin
               fill = 0;
            end
         endcase
         r.top   = top_tag();
         r.empty = (fill == 0);
         pending_results.push_back(r);
      endfunction

      function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
         if (exp !== act) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, act);
         end
      endfunction

      function void check_response(logic [47:0] d);
         merge_result_type e;
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: response %h arrived with nothing expected", $time, d);
            return;
         end
         e = pending_results.pop_front();
         compare_field("out_value", e.value, d[31:0]);
         compare_field("out_valid", e.valid, d[32]);
         compare_field("out_tag", e.tag, d[36:33]);
         compare_field("top_tag", e.top, d[40:37]);
         compare_field("heap_empty", e.empty, d[41]);
         compare_field("status", e.status, d[43:42]);
      endfunction
   endclass

endpackage

@@ tb/tb_top.sv @@
// Top-level bench for k_way_merge_min_heap_unit: drives merge sequences and noise items,
// throttles both stream sides and checks every response. Depends on kwm_pkg and kwm_tb_pkg.
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   import kwm_pkg::*;
   import kwm_tb_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int PHASE_ITEMS = 180;
   localparam int TX_IDLE [4] = '{0, 59, 0, 36};
   localparam int RX_STALL [4] = '{0, 0, 59, 36};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // elem_value[31:0], list_tag[35:32], zero pad
   logic [1:0]  req_tuser = '0;   // opcode[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // out_value, out_valid, out_tag, top_tag, heap_empty, status

   int          tx_idle_pct = 0;
   int          rx_stall_pct = 0;
   logic        rx_hold = 1'b0;
   int          items_sent = 0;
   int          cycle_count = 0;

   merge_heap_mirror mirror;

   k_way_merge_min_heap_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (rx_hold) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         mirror.check_response(rsp_tdata);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Offers one item, waits for it to be taken and records it in the mirror.
   task automatic send(input op_type op, input logic [31:0] elem, input logic [3:0] tag);
      if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0000, tag, elem};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      mirror.note_request(op, elem, tag);
      items_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (mirror.pending() != 0);
   endtask

   // One well-formed merge: load the list heads, then keep advancing whichever list
   // is on top until the heap runs dry, with the odd stray item mixed in.
   task automatic merge_run();
      longint      next_val [16];
      int          left [16];
      bit          used [16];
      int          k;
      int          mode;
      logic [3:0]  t;
      longint      nv;
      send(OP_CLEAR, $urandom, 4'($urandom_range(15)));
      k    = $urandom_range(16, 1);
      mode = $urandom_range(2);
      foreach (used[i]) used[i] = 1'b0;
      for (int n = 0; n < k; n++) begin
         t = 4'($urandom_range(15));
         while (used[t]) t = 4'($urandom_range(15));
         used[t] = 1'b1;
         case (mode)
            0: next_val[t] = longint'(int'($urandom));
            1: next_val[t] = longint'($urandom_range(8)) - 4;
            default: next_val[t] = $urandom_range(1) ? 64'sd2147483647 - $urandom_range(20)
                                                      : -64'sd2147483648 + $urandom_range(20);
         endcase
         left[t] = $urandom_range(6);
         send(OP_INSERT, next_val[t][31:0], t);
      end
      if ($urandom_range(7) == 0) begin
         send(OP_INSERT, $urandom, 4'($urandom_range(15)));
      end
      while (mirror.size() > 0) begin
         if ($urandom_range(99) < 6) begin
            send(op_type'($urandom_range(3)), $urandom, 4'($urandom_range(15)));
         end else begin
            t = mirror.top_tag();
            if (used[t] && left[t] > 0) begin
               if (mode == 1) nv = next_val[t] + $urandom_range(2);
               else if ($urandom_range(3) == 0) nv = next_val[t] + $urandom_range(3);
               else nv = next_val[t] + $urandom_range(100000);
               if (nv > 64'sd2147483647) begin
                  left[t] = 0;
                  send(OP_POP, $urandom, 4'($urandom_range(15)));
               end else begin
                  next_val[t] = nv;
                  left[t]--;
                  send(OP_REPLACE, nv[31:0], 4'($urandom_range(15)));
               end
            end else begin
               send(OP_POP, $urandom, 4'($urandom_range(15)));
            end
         end
      end
      if ($urandom_range(4) == 0) begin
         send(op_type'($urandom_range(2, 1)), $urandom, 4'($urandom_range(15)));
      end
   endtask

   initial begin
      int target;
      mirror = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Removal from an empty heap, then heads at the value extremes and a tie on value.
      send(OP_POP, 32'h0, 4'h0);
      send(OP_REPLACE, 32'hFFFF_FFFF, 4'hF);
      send(OP_INSERT, 32'h7FFF_FFFF, 4'hF);
      send(OP_INSERT, 32'h8000_0000, 4'h0);
      send(OP_INSERT, 32'hFFFF_FFFF, 4'h9);
      send(OP_INSERT, 32'h0000_0000, 4'h5);
      send(OP_INSERT, 32'h0000_0005, 4'h3);
      send(OP_INSERT, 32'h0000_0005, 4'h2);
      send(OP_REPLACE, 32'h7FFF_FFFF, 4'h6);
      send(OP_REPLACE, 32'h8000_0000, 4'hA);
      send(OP_POP, 32'h1234_5678, 4'hC);
      // Fill to capacity with equal values, then an insert into the full heap.
      for (int n = 0; n < 11; n++) begin
         send(OP_INSERT, 32'h0000_0005, 4'(15 - n));
      end
      send(OP_INSERT, 32'h0000_0001, 4'h1);
      send(OP_CLEAR, 32'hFFFF_FFFF, 4'hF);
      send(OP_POP, 32'h0, 4'h0);
      drain();

      for (int p = 0; p < 4; p++) begin
         tx_idle_pct = TX_IDLE[p];
         rx_stall_pct <= RX_STALL[p];
         if (p == 2) begin
            // Hold the response side off for a long stretch so the input backs up.
            fork
               begin
                  rx_hold <= 1'b1;
                  repeat (160) @(posedge clock);
                  rx_hold <= 1'b0;
               end
            join_none
         end
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) merge_run();
         drain();
      end

      repeat (30) @(posedge clock);
      if (mirror.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ k_way_merge_min_heap_unit.f @@
design/kwm_pkg.sv
design/kwm_ram.sv
design/kwm_cmp.sv
design/k_way_merge_min_heap_unit.sv
tb/kwm_tb_pkg.sv
tb/tb_top.sv
